// ----- rtl/core/rirt_pkg.sv -----
// shared types and constants of the recent idle ratio tracker
package rirt_pkg;

  localparam int TS_W           = 32;
  localparam int KIND_W         = 2;
  localparam int RES_W          = 10;
  localparam int NKINDS         = 3;
  localparam int WINDOW_MS_DEF  = 1000;

  localparam logic             FUNC_ENTRY   = 1'b0;
  localparam logic             FUNC_EXIT    = 1'b1;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  typedef struct packed {
    logic              func;
    logic [KIND_W-1:0] idle_kind;
    logic [TS_W-1:0]   now_ms;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] ratio_total;
    logic [RES_W-1:0] ratio_kind0;
    logic [RES_W-1:0] ratio_kind1;
    logic [RES_W-1:0] ratio_kind2;
    logic [TS_W-1:0]  last_exit_time;
  } out_t;

endpackage

// ----- rtl/core/rirt_decay.sv -----
// one residency channel: scale by the kept share of the window, add, saturate; on clear, take the addend alone
module rirt_decay #(
  parameter int WINDOW_MS = rirt_pkg::WINDOW_MS_DEF,
  parameter int WB        = 10,
  parameter int GW        = 42,
  parameter int SHIFT     = 40
) (
  input  logic          clear,
  input  logic [GW-1:0] scale,
  input  logic [WB-1:0] cur,
  input  logic [WB-1:0] add,
  output logic [WB-1:0] nxt
);
  import rirt_pkg::*;

  localparam int PW = GW + WB;

  logic [PW-1:0] prod;
  logic [WB-1:0] dec;
  logic [WB:0]   sum;
  logic [WB-1:0] sat;

  // reciprocal multiply, exact floor for every product below the window squared
  assign prod = PW'(scale) * PW'(cur);
  assign dec  = prod[SHIFT +: WB];
  assign sum  = {1'b0, dec} + {1'b0, add};
  assign sat  = (sum >= (WB+1)'(WINDOW_MS)) ? WB'(WINDOW_MS) : sum[WB-1:0];
  assign nxt  = clear ? add : sat;

endmodule

// ----- rtl/core/recent_idle_ratio_tracker.sv -----
// top level of the recent idle ratio tracker
// a request accepted into the stage one register passes on to the result register, which drives the outputs
// throughput: one request per cycle, stalls only when both stages are full and out_stall is high
// the residency feedback loop is one multiply, add and clamp in stage two
// reset clears timestamps, residencies and both valid flags
// the first result after reset reflects zero history
module recent_idle_ratio_tracker #(
  parameter int WINDOW_MS = rirt_pkg::WINDOW_MS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rirt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rirt_pkg::out_t out_data
);
  import rirt_pkg::*;

  // residency width holds the window itself
  localparam int WB    = $clog2(WINDOW_MS + 1);
  // shift large enough that the rounded-up reciprocal gives an exact floor
  localparam int SHIFT = 4 * WB;
  localparam int SP1   = SHIFT + 1;
  localparam int MW    = 3 * WB + 2;
  localparam int GW    = WB + MW;
  localparam logic [SHIFT:0] POW_S = SP1'(1) << SHIFT;
  localparam logic [SHIFT:0] RECIP =
    (POW_S + SP1'(WINDOW_MS) - SP1'(1)) / SP1'(WINDOW_MS);

  // handshake enables per stage
  logic out_en;
  logic s1_en;
  logic in_take;
  logic s1_move;

  // stage one state: timestamps live here so stage two never waits on them
  logic [TS_W-1:0] entry_time_r, entry_time_nxt;
  logic [TS_W-1:0] prev_exit_r, prev_exit_nxt;

  // stage one pipeline register
  logic              s1_valid_r;
  logic              s1_upd_r,   s1_upd_nxt;
  logic              s1_full_r,  s1_full_nxt;
  logic [KIND_W-1:0] s1_kind_r;
  logic [WB-1:0]     s1_idle_r,  s1_idle_nxt;
  logic [GW-1:0]     s1_scale_r, s1_scale_nxt;
  logic [TS_W-1:0]   s1_last_r;

  // stage one arithmetic
  logic            counted;
  logic            is_exit;
  logic [TS_W-1:0] interval;
  logic [TS_W-1:0] idle;
  logic [WB-1:0]   keep;

  // residency state and its candidates
  logic [WB-1:0] total_r;
  logic [WB-1:0] total_nxt;
  logic [WB-1:0] kind_r   [NKINDS];
  logic [WB-1:0] kind_nxt [NKINDS];

  logic out_valid_r;
  out_t out_data_r;

  // the result register frees when empty or taken; stage one frees into it
  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;
  assign in_take  = in_valid && s1_en;
  assign s1_move  = s1_valid_r && out_en;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- stage one
  // ignored kind touches nothing; entry records its time; exit measures
  assign counted  = (in_data.idle_kind != KIND_IGNORED);
  assign is_exit  = counted && (in_data.func == FUNC_EXIT);
  assign interval = in_data.now_ms - prev_exit_r;
  assign idle     = in_data.now_ms - entry_time_r;
  // only meaningful when interval is under the window
  assign keep     = WB'(WINDOW_MS) - interval[WB-1:0];

  always_comb begin
    s1_full_nxt  = (interval >= TS_W'(WINDOW_MS));
    // clamping the idle time early gives the same saturated sum later
    s1_idle_nxt  = (idle >= TS_W'(WINDOW_MS)) ? WB'(WINDOW_MS) : idle[WB-1:0];
    // kept share of the window times the reciprocal, free of stage two state
    s1_scale_nxt = GW'(keep) * GW'(RECIP);
    s1_upd_nxt   = is_exit;
    entry_time_nxt = (counted && (in_data.func == FUNC_ENTRY)) ?
                     in_data.now_ms : entry_time_r;
    prev_exit_nxt  = is_exit ? in_data.now_ms : prev_exit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      entry_time_r <= '0;
      prev_exit_r  <= '0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= in_valid;
      end
      if (in_take) begin
        entry_time_r <= entry_time_nxt;
        prev_exit_r  <= prev_exit_nxt;
      end
    end
  end

  // stage one payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_upd_r   <= s1_upd_nxt;
      s1_full_r  <= s1_full_nxt;
      s1_kind_r  <= in_data.idle_kind;
      s1_idle_r  <= s1_idle_nxt;
      s1_scale_r <= s1_scale_nxt;
      s1_last_r  <= prev_exit_nxt;
    end
  end

  // ---------------------------------------------------------------- stage two
  // total channel always takes the idle time
  rirt_decay #(
    .WINDOW_MS (WINDOW_MS),
    .WB        (WB),
    .GW        (GW),
    .SHIFT     (SHIFT)
  ) u_total (
    .clear (s1_full_r),
    .scale (s1_scale_r),
    .cur   (total_r),
    .add   (s1_idle_r),
    .nxt   (total_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (s1_move && s1_upd_r) begin
      total_r <= total_nxt;
    end
  end

  // per-kind channels: the exiting kind gets the idle time, the others decay
  // (or clear on a full window)
  for (genvar k = 0; k < NKINDS; k++) begin : g_kind
    logic [WB-1:0] add;

    assign add = (s1_kind_r == KIND_W'(k)) ? s1_idle_r : '0;

    rirt_decay #(
      .WINDOW_MS (WINDOW_MS),
      .WB        (WB),
      .GW        (GW),
      .SHIFT     (SHIFT)
    ) u_kind (
      .clear (s1_full_r),
      .scale (s1_scale_r),
      .cur   (kind_r[k]),
      .add   (add),
      .nxt   (kind_nxt[k])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        kind_r[k] <= '0;
      end else if (s1_move && s1_upd_r) begin
        kind_r[k] <= kind_nxt[k];
      end
    end
  end

  // ------------------------------------------------------------ result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // results carry the low bits of each residency
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.ratio_total    <= RES_W'(s1_upd_r ? total_nxt   : total_r);
      out_data_r.ratio_kind0    <= RES_W'(s1_upd_r ? kind_nxt[0] : kind_r[0]);
      out_data_r.ratio_kind1    <= RES_W'(s1_upd_r ? kind_nxt[1] : kind_r[1]);
      out_data_r.ratio_kind2    <= RES_W'(s1_upd_r ? kind_nxt[2] : kind_r[2]);
      out_data_r.last_exit_time <= s1_last_r;
    end
  end

endmodule

// ----- bench/tb.sv -----
// testbench for the recent idle ratio tracker: directed and random requests checked field by field
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rirt_pkg::*;

  // sliding window of the instance, which keeps its default
  localparam int unsigned WINDOW = WINDOW_MS_DEF;

  // idle kinds that are counted; the fourth one is KIND_IGNORED from the package
  localparam logic [KIND_W-1:0] KIND_DEEP  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MODE3 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODE2 = 2'd2;

  localparam out_t NO_RESULT = '0;

  // idling per phase, in percent: none, sender, receiver, both lightly
  localparam int NUM_PHASES = 4;
  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 78, 0, 9};
  localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 78, 9};
  localparam int COUNTED_PER_PHASE = 310;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // expectation typed into the table travels with the request it belongs to
  logic row_typed = 1'b0;
  out_t row_res = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  out_t expected_results [$];

  // our own copy of the tracker state, all zero after reset
  logic [TS_W-1:0] entry_ms = '0;
  logic [TS_W-1:0] exit_ms = '0;
  int unsigned total_ms = 0;
  int unsigned kind_ms [NKINDS] = '{default: 0};

  // random sequence state: a running millisecond clock and an exit still owed
  logic [TS_W-1:0] clock_ms = '0;
  logic exit_owed = 1'b0;
  logic [KIND_W-1:0] owed_kind = '0;
  int unsigned owed_idle = 0;

  always #5 clk = ~clk;

  recent_idle_ratio_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // limit everything to the window
  function automatic int unsigned clamp_window(longint unsigned v);
    return (v >= WINDOW) ? WINDOW : int'(v);
  endfunction

  // scale a channel by (window - gap) / window, truncating
  function automatic longint unsigned fade(int unsigned v, logic [TS_W-1:0] gap);
    longint unsigned keep;
    keep = longint'(WINDOW) - longint'(gap);
    return (keep * longint'(v)) / longint'(WINDOW);
  endfunction

  // advance the residency estimate by one request and return what the block reports
  function automatic out_t track_idle_event(in_t req);
    logic [TS_W-1:0] gap;
    logic [TS_W-1:0] idle;
    longint unsigned add;
    out_t res;
    if (req.idle_kind != KIND_IGNORED) begin
      if (req.func == FUNC_ENTRY) begin
        entry_ms = req.now_ms;
      end else begin
        // differences wrap modulo 2^32
        gap = req.now_ms - exit_ms;
        idle = req.now_ms - entry_ms;
        if (gap >= WINDOW) begin
          // a full window since the last exit: history is dropped
          total_ms = clamp_window(idle);
          for (int k = 0; k < NKINDS; k++) begin
            kind_ms[k] = (k == int'(req.idle_kind)) ? total_ms : 0;
          end
        end else begin
          total_ms = clamp_window(fade(total_ms, gap) + idle);
          for (int k = 0; k < NKINDS; k++) begin
            add = (k == int'(req.idle_kind)) ? longint'(idle) : 0;
            kind_ms[k] = clamp_window(fade(kind_ms[k], gap) + add);
          end
        end
        exit_ms = req.now_ms;
      end
    end
    res.ratio_total    = total_ms[RES_W-1:0];
    res.ratio_kind0    = kind_ms[0][RES_W-1:0];
    res.ratio_kind1    = kind_ms[1][RES_W-1:0];
    res.ratio_kind2    = kind_ms[2][RES_W-1:0];
    res.last_exit_time = exit_ms;
    return res;
  endfunction

  // mostly entry/exit pairs of one kind with random spacing, the rest noise
  function automatic in_t next_random_request();
    in_t req;
    int pick;
    pick = $urandom_range(99);
    if (exit_owed && pick < 90) begin
      clock_ms += owed_idle;
      req = '{FUNC_EXIT, owed_kind, clock_ms};
      exit_owed = 1'b0;
    end else if (!exit_owed && pick < 75) begin
      // gap since the last exit, now and then longer than the window
      clock_ms += $urandom_range(400);
      if ($urandom_range(9) == 0) begin
        clock_ms += $urandom_range(2000);
      end
      owed_kind = KIND_W'($urandom_range(2));
      owed_idle = ($urandom_range(7) == 0) ? 0 : $urandom_range(900);
      exit_owed = 1'b1;
      req = '{FUNC_ENTRY, owed_kind, clock_ms};
    end else if (pick < 92) begin
      // stray request close to the running clock, any kind, either direction
      req.func      = 1'($urandom_range(1));
      req.idle_kind = KIND_W'($urandom_range(3));
      req.now_ms    = clock_ms + $urandom_range(50);
    end else begin
      // anything at all, timestamps anywhere on the wrapping counter
      req.func      = 1'($urandom_range(1));
      req.idle_kind = KIND_W'($urandom_range(3));
      req.now_ms    = $urandom;
    end
    return req;
  endfunction

  // offer one request, idling first as the phase asks, and hold it until taken
  task automatic send_request(input in_t req, input logic typed, input out_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= req;
    row_typed <= typed;
    row_res   <= typed_res;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every expected result is back; returns at a falling edge
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  // directed requests: expectations typed in only where they are plain
  typedef struct packed {
    in_t  req;
    logic typed;
    out_t res;
  } directed_row_t;

  localparam int NUM_DIRECTED = 22;
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // ignored kind straight after reset, both directions: zero history
    '{'{FUNC_ENTRY, KIND_IGNORED, 32'hFFFF_FFFF}, 1'b1, NO_RESULT},
    '{'{FUNC_EXIT,  KIND_IGNORED, 32'h1234_5678}, 1'b1, NO_RESULT},
    // exit with no entry: idle counted from a zero entry time
    '{'{FUNC_EXIT,  KIND_DEEP,    32'd999}, 1'b1, '{10'd999, 10'd999, 10'd0, 10'd0, 32'd999}},
    // exactly one window since the last exit: history dropped, saturated
    '{'{FUNC_EXIT,  KIND_MODE3,   32'd1999}, 1'b1, '{10'd1000, 10'd0, 10'd1000, 10'd0, 32'd1999}},
    // one short of the window: heavy decay then saturation
    '{'{FUNC_EXIT,  KIND_MODE2,   32'd2998}, 1'b0, NO_RESULT},
    '{'{FUNC_ENTRY, KIND_DEEP,    32'd3000}, 1'b0, NO_RESULT},
    '{'{FUNC_EXIT,  KIND_DEEP,    32'd3000}, 1'b0, NO_RESULT},
    '{'{FUNC_ENTRY, KIND_MODE3,   32'd3100}, 1'b0, NO_RESULT},
    '{'{FUNC_EXIT,  KIND_MODE3,   32'd3350}, 1'b0, NO_RESULT},
    // ignored entry must leave the stored start alone
    '{'{FUNC_ENTRY, KIND_IGNORED, 32'd3400}, 1'b0, NO_RESULT},
    '{'{FUNC_EXIT,  KIND_MODE2,   32'd3500}, 1'b0, NO_RESULT},
    // top of the counter: huge interval and idle, everything at the window
    '{'{FUNC_EXIT,  KIND_DEEP,    32'hFFFF_FFFF}, 1'b1,
      '{10'd1000, 10'd1000, 10'd0, 10'd0, 32'hFFFF_FFFF}},
    // idle period and interval across the wrap of the counter
    '{'{FUNC_ENTRY, KIND_MODE2,   32'hFFFF_FF00}, 1'b0, NO_RESULT},
    '{'{FUNC_EXIT,  KIND_MODE2,   32'h0000_0010}, 1'b0, NO_RESULT},
    '{'{FUNC_EXIT,  KIND_MODE2,   32'h0000_0010}, 1'b0, NO_RESULT},
    // timestamp running backwards
    '{'{FUNC_EXIT,  KIND_MODE3,   32'h0000_0000}, 1'b0, NO_RESULT},
    '{'{FUNC_ENTRY, KIND_DEEP,    32'h7FFF_FFFF}, 1'b0, NO_RESULT},
    '{'{FUNC_EXIT,  KIND_DEEP,    32'h8000_0000}, 1'b0, NO_RESULT},
    '{'{FUNC_ENTRY, KIND_MODE3,   32'h8000_0001}, 1'b0, NO_RESULT},
    '{'{FUNC_EXIT,  KIND_MODE3,   32'h8000_03E8}, 1'b0, NO_RESULT},
    '{'{FUNC_ENTRY, KIND_DEEP,    32'h8000_03E9}, 1'b0, NO_RESULT},
    '{'{FUNC_EXIT,  KIND_DEEP,    32'h8000_07CF}, 1'b0, NO_RESULT}
  };

  // receiver stalls at random at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // record the expectation of each accepted request, then check each result taken
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = track_idle_event(in_data);
        if (row_typed) begin
          want = row_res;
        end
        expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %p", out_data);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.ratio_total !== want.ratio_total) begin
            $error("ratio_total: expected %0d, actual %0d",
                   want.ratio_total, out_data.ratio_total);
            mismatch_count++;
          end
          if (out_data.ratio_kind0 !== want.ratio_kind0) begin
            $error("ratio_kind0: expected %0d, actual %0d",
                   want.ratio_kind0, out_data.ratio_kind0);
            mismatch_count++;
          end
          if (out_data.ratio_kind1 !== want.ratio_kind1) begin
            $error("ratio_kind1: expected %0d, actual %0d",
                   want.ratio_kind1, out_data.ratio_kind1);
            mismatch_count++;
          end
          if (out_data.ratio_kind2 !== want.ratio_kind2) begin
            $error("ratio_kind2: expected %0d, actual %0d",
                   want.ratio_kind2, out_data.ratio_kind2);
            mismatch_count++;
          end
          if (out_data.last_exit_time !== want.last_exit_time) begin
            $error("last_exit_time: expected %0h, actual %0h",
                   want.last_exit_time, out_data.last_exit_time);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    in_t req;
    int counted;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling on either side
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end
    wait_for_drain();

    // random phases, each started from an empty pipeline
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = SEND_IDLE_PCT[p];
      recv_stall_pct = RECV_STALL_PCT[p];
      // odd phases start just below the wrap of the counter
      clock_ms  = (p % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(150000) : $urandom;
      exit_owed = 1'b0;
      counted   = 0;
      @(posedge clk);
      while (counted < COUNTED_PER_PHASE) begin
        req = next_random_request();
        send_request(req, 1'b0, NO_RESULT);
        if (req.idle_kind != KIND_IGNORED) begin
          counted++;
        end
      end
      wait_for_drain();
    end

    // wait on for any stray result still in the pipeline
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rirt_pkg.sv
rtl/core/rirt_decay.sv
rtl/core/recent_idle_ratio_tracker.sv
bench/tb.sv
